>>> hdl/aip_pkg.sv
// Package for the ASCII integer parser: phase, status, base and register codes,
// the parse state type and the per-digit and end-of-string functions.
// Depends on nothing; used by ascii_integer_parser.
package aip_pkg;

  localparam int unsigned MAX_LEN = 64;
  localparam int unsigned SEEN_W  = $clog2(MAX_LEN + 1);

  localparam logic [2:0] PH_WS     = 3'd0;
  localparam logic [2:0] PH_SIGNED = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_AFTERX = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FORMAT   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_ARG      = 2'd3;

  localparam logic [4:0] BASE_AUTO = 5'd0;
  localparam logic [4:0] BASE_BIN  = 5'd2;
  localparam logic [4:0] BASE_OCT  = 5'd8;
  localparam logic [4:0] BASE_DEC  = 5'd10;
  localparam logic [4:0] BASE_HEX  = 5'd16;

  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;
  localparam logic [1:0] WSEL_64 = 2'd3;

  localparam logic [1:0] CFG_BASE     = 2'd0;
  localparam logic [1:0] CFG_UNSIGNED = 2'd1;
  localparam logic [1:0] CFG_WIDTH    = 2'd2;

  localparam logic [4:0] RST_BASE     = BASE_DEC;
  localparam logic       RST_UNSIGNED = 1'b0;
  localparam logic [1:0] RST_WIDTH    = WSEL_32;

  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_CR    = 16'h000D;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_PLUS  = 16'h002B;
  localparam logic [15:0] CH_MINUS = 16'h002D;
  localparam logic [15:0] CH_ZERO  = 16'h0030;
  localparam logic [15:0] CH_NINE  = 16'h0039;
  localparam logic [15:0] CH_UA    = 16'h0041;
  localparam logic [15:0] CH_UF    = 16'h0046;
  localparam logic [15:0] CH_UX    = 16'h0058;
  localparam logic [15:0] CH_LA    = 16'h0061;
  localparam logic [15:0] CH_LF    = 16'h0066;
  localparam logic [15:0] CH_LX    = 16'h0078;

  localparam logic [63:0] MAX_8  = 64'h0000_0000_0000_00FF;
  localparam logic [63:0] MAX_16 = 64'h0000_0000_0000_FFFF;
  localparam logic [63:0] MAX_32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] MAX_64 = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [63:0] DEC_LIM_8  = MAX_8 / 64'd10;
  localparam logic [63:0] DEC_LIM_16 = MAX_16 / 64'd10;
  localparam logic [63:0] DEC_LIM_32 = MAX_32 / 64'd10;
  localparam logic [63:0] DEC_LIM_64 = MAX_64 / 64'd10;
  localparam logic [4:0]  DEC_REM_8  = 5'(MAX_8 % 64'd10);
  localparam logic [4:0]  DEC_REM_16 = 5'(MAX_16 % 64'd10);
  localparam logic [4:0]  DEC_REM_32 = 5'(MAX_32 % 64'd10);
  localparam logic [4:0]  DEC_REM_64 = 5'(MAX_64 % 64'd10);

  typedef struct packed {
    logic [2:0]  phase;
    logic [63:0] acc;
    logic        neg;
    logic        ovf;
    logic [4:0]  base;
    logic [6:0]  cnt;
    logic [1:0]  err;
  } parse_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic [6:0]  count;
  } result_t;

  function automatic logic [63:0] width_max(logic [1:0] wsel);
    logic [63:0] m;
    unique case (wsel)
      WSEL_8:  m = MAX_8;
      WSEL_16: m = MAX_16;
      WSEL_32: m = MAX_32;
      default: m = MAX_64;
    endcase
    return m;
  endfunction

  function automatic logic base_ok(logic [4:0] b);
    return (b == BASE_AUTO) || (b == BASE_BIN) || (b == BASE_OCT) ||
           (b == BASE_DEC) || (b == BASE_HEX);
  endfunction

  function automatic logic is_space(logic [15:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [63:0] digit_limit(logic [4:0] b, logic [1:0] wsel);
    logic [63:0] m;
    logic [63:0] l;
    m = width_max(wsel);
    l = m;
    if (b == BASE_BIN) begin
      l = m >> 1;
    end else if (b == BASE_OCT) begin
      l = m >> 3;
    end else if (b == BASE_HEX) begin
      l = m >> 4;
    end else if (b == BASE_DEC) begin
      unique case (wsel)
        WSEL_8:  l = DEC_LIM_8;
        WSEL_16: l = DEC_LIM_16;
        WSEL_32: l = DEC_LIM_32;
        default: l = DEC_LIM_64;
      endcase
    end
    return l;
  endfunction

  function automatic logic [4:0] digit_rem(logic [4:0] b, logic [1:0] wsel);
    logic [4:0] r;
    r = 5'd0;
    if (b == BASE_BIN) begin
      r = 5'd1;
    end else if (b == BASE_OCT) begin
      r = 5'd7;
    end else if (b == BASE_HEX) begin
      r = 5'd15;
    end else if (b == BASE_DEC) begin
      unique case (wsel)
        WSEL_8:  r = DEC_REM_8;
        WSEL_16: r = DEC_REM_16;
        WSEL_32: r = DEC_REM_32;
        default: r = DEC_REM_64;
      endcase
    end
    return r;
  endfunction

  function automatic parse_t take_digit(parse_t s, logic [15:0] c, logic [1:0] wsel);
    parse_t      n;
    logic        is_dig;
    logic [4:0]  d;
    logic [63:0] lim;
    logic [4:0]  rem;
    logic [63:0] prod;
    n      = s;
    is_dig = 1'b1;
    d      = 5'd0;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      d = 5'(c - CH_ZERO);
    end else if ((c >= CH_UA) && (c <= CH_UF)) begin
      d = 5'(c - CH_UA) + 5'd10;
    end else if ((c >= CH_LA) && (c <= CH_LF)) begin
      d = 5'(c - CH_LA) + 5'd10;
    end else begin
      is_dig = 1'b0;
    end
    lim = digit_limit(s.base, wsel);
    rem = digit_rem(s.base, wsel);
    unique case (s.base)
      BASE_BIN: prod = {s.acc[62:0], 1'b0};
      BASE_OCT: prod = {s.acc[60:0], 3'b000};
      BASE_DEC: prod = {s.acc[60:0], 3'b000} + {s.acc[62:0], 1'b0};
      BASE_HEX: prod = {s.acc[59:0], 4'b0000};
      default:  prod = s.acc;
    endcase
    if (!is_dig) begin
      n.phase = PH_DONE;
    end else if ((s.base == BASE_AUTO) || (d >= s.base)) begin
      n.err   = ST_FORMAT;
      n.phase = PH_DONE;
    end else begin
      n.cnt = s.cnt + 7'd1;
      if ((s.acc < lim) || ((s.acc == lim) && (d <= rem))) begin
        n.acc = prod + {59'd0, d};
      end else begin
        n.ovf = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic parse_t clear_state(logic [4:0] b);
    parse_t s;
    s.phase = PH_WS;
    s.acc   = '0;
    s.neg   = 1'b0;
    s.ovf   = 1'b0;
    s.base  = b;
    s.cnt   = '0;
    s.err   = ST_OK;
    return s;
  endfunction

  function automatic result_t finish(parse_t s, logic uns, logic [1:0] wsel);
    result_t     r;
    logic [63:0] umax;
    logic [63:0] half;
    logic [63:0] mag;
    umax     = width_max(wsel);
    half     = umax ^ (umax >> 1);
    mag      = s.acc;
    r.value  = '0;
    r.status = ST_OK;
    r.count  = '0;
    if (!base_ok(s.base) || (s.err == ST_ARG)) begin
      r.status = ST_ARG;
    end else if ((s.err != ST_OK) || (s.phase == PH_WS) || (s.phase == PH_SIGNED) ||
                 (s.phase == PH_AFTERX)) begin
      r.status = ST_FORMAT;
    end else begin
      r.count = s.cnt;
      if (uns) begin
        if (s.ovf) begin
          r.value  = umax;
          r.status = ST_OVERFLOW;
        end else begin
          r.value = s.neg ? ((64'd0 - s.acc) & umax) : s.acc;
        end
      end else begin
        if (s.ovf || (s.neg && (mag > half)) || (!s.neg && (mag >= half))) begin
          r.status = ST_OVERFLOW;
          mag      = s.neg ? half : (umax >> 1);
        end
        r.value = s.neg ? ((64'd0 - mag) & umax) : mag;
      end
    end
    return r;
  endfunction

endpackage

>>> hdl/ascii_integer_parser.sv
// Top level of the ASCII integer parser: input register, parse state update,
// end-of-string snapshot, result register and APB register bank.
// Depends on aip_pkg.
//
// Usage: one character code unit per slave transaction (tdata code unit, tuser
// has_char, tlast marks the end of the string). The unit on tlast yields one
// master transaction carrying value, consumed count and status; other units
// yield none. Registers number_base (0x0), unsigned_mode (0x4) and width_select
// (0x8) must be written over APB only while idle; the block does not check.
// Throughput: one unit per cycle while s_axis_tready is high; the per-unit path
// is one radix shift-add and a limit compare on the 64-bit accumulator between
// the input register and the parse state. The last unit moves on to the snapshot
// (state update), then to the result register (range clamp and negate).
// A stalled receiver holds the result register; units keep flowing while a
// second finished string waits in the snapshot stage, and s_axis_tready drops
// once the last unit of a third string sits in the input register.
// Reset clears all pipeline valids, sets the registers to base 10, signed,
// 32-bit, and returns the parse state to whitespace skipping.
module ascii_integer_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
  input  logic [0:0]  s_axis_tuser,   // [0] has_char
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [63:0] value, [70:64] consumed_count, [71] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0]  base_q;
  logic        unsigned_q;
  logic [1:0]  wsel_q;

  logic        s1_valid_q;
  logic [15:0] s1_code_q;
  logic        s1_has_q;
  logic        s1_last_q;

  aip_pkg::parse_t                 st_q;
  logic [aip_pkg::SEEN_W-1:0]      seen_q;
  logic                            fin_valid_q;
  aip_pkg::parse_t                 fin_q;
  aip_pkg::parse_t                 fin_d;

  logic        out_valid_q;
  logic [63:0] out_value_q;
  logic [1:0]  out_status_q;
  logic [6:0]  out_count_q;

  logic        out_free;
  logic        fin_free;
  logic        fin_adv;
  logic        s1_adv;
  logic        take;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  aip_pkg::parse_t pre;
  aip_pkg::parse_t post;
  aip_pkg::parse_t unit_st;
  aip_pkg::result_t res;
  logic            do_dig;
  logic            first_u;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fin_free      = !fin_valid_q || out_free;
  assign fin_adv       = fin_valid_q && out_free;
  assign s1_adv        = s1_valid_q && (!s1_last_q || fin_free);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_count_q, out_value_q};
  assign m_axis_tuser  = out_status_q;

  always_comb begin
    unique case (cfg_idx)
      aip_pkg::CFG_BASE:     prdata = {27'd0, base_q};
      aip_pkg::CFG_UNSIGNED: prdata = {31'd0, unsigned_q};
      aip_pkg::CFG_WIDTH:    prdata = {30'd0, wsel_q};
      default:               prdata = '0;
    endcase
  end

  // Per-unit phase step; the digit itself goes through one shared take_digit.
  always_comb begin
    pre     = st_q;
    do_dig  = 1'b0;
    first_u = 1'b0;
    if (pre.phase != aip_pkg::PH_DONE) begin
      if (!aip_pkg::base_ok(pre.base)) begin
        pre.err   = aip_pkg::ST_ARG;
        pre.phase = aip_pkg::PH_DONE;
      end else begin
        unique case (pre.phase)
          aip_pkg::PH_WS: begin
            priority if (aip_pkg::is_space(s1_code_q)) begin
              pre.cnt = pre.cnt + 7'd1;
            end else if (s1_code_q == aip_pkg::CH_MINUS) begin
              pre.neg   = 1'b1;
              pre.cnt   = pre.cnt + 7'd1;
              pre.phase = aip_pkg::PH_SIGNED;
            end else if (s1_code_q == aip_pkg::CH_PLUS) begin
              pre.cnt   = pre.cnt + 7'd1;
              pre.phase = aip_pkg::PH_SIGNED;
            end else begin
              first_u = 1'b1;
            end
          end
          aip_pkg::PH_SIGNED: begin
            first_u = 1'b1;
          end
          aip_pkg::PH_ZERO: begin
            if ((s1_code_q == aip_pkg::CH_LX) || (s1_code_q == aip_pkg::CH_UX)) begin
              pre.base  = aip_pkg::BASE_HEX;
              pre.cnt   = pre.cnt + 7'd2;
              pre.phase = aip_pkg::PH_AFTERX;
            end else begin
              if (pre.base == aip_pkg::BASE_AUTO) begin
                pre.base = aip_pkg::BASE_OCT;
              end
              pre.cnt   = pre.cnt + 7'd1;
              pre.phase = aip_pkg::PH_DIGITS;
              do_dig    = 1'b1;
            end
          end
          aip_pkg::PH_AFTERX: begin
            pre.phase = aip_pkg::PH_DIGITS;
            do_dig    = 1'b1;
          end
          default: begin
            do_dig = 1'b1;
          end
        endcase
        if (first_u) begin
          if ((s1_code_q == aip_pkg::CH_ZERO) &&
              ((pre.base == aip_pkg::BASE_AUTO) || (pre.base == aip_pkg::BASE_HEX))) begin
            pre.phase = aip_pkg::PH_ZERO;
          end else begin
            if (pre.base == aip_pkg::BASE_AUTO) begin
              pre.base = aip_pkg::BASE_DEC;
            end
            pre.phase = aip_pkg::PH_DIGITS;
            do_dig    = 1'b1;
          end
        end
      end
    end
    post    = do_dig ? aip_pkg::take_digit(pre, s1_code_q, wsel_q) : pre;
    take    = s1_has_q && (seen_q < aip_pkg::SEEN_W'(aip_pkg::MAX_LEN));
    unit_st = take ? post : st_q;
    // Resolve a lone leading zero at the end of the string.
    fin_d   = unit_st;
    if (unit_st.phase == aip_pkg::PH_ZERO) begin
      if (unit_st.base == aip_pkg::BASE_AUTO) begin
        fin_d.base = aip_pkg::BASE_OCT;
      end
      fin_d.cnt   = unit_st.cnt + 7'd1;
      fin_d.phase = aip_pkg::PH_DIGITS;
    end
    res = aip_pkg::finish(fin_q, unsigned_q, wsel_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= aip_pkg::RST_BASE;
      unsigned_q <= aip_pkg::RST_UNSIGNED;
      wsel_q     <= aip_pkg::RST_WIDTH;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        aip_pkg::CFG_BASE:     base_q     <= pwdata[4:0];
        aip_pkg::CFG_UNSIGNED: unsigned_q <= pwdata[0];
        aip_pkg::CFG_WIDTH:    wsel_q     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_code_q <= s_axis_tdata;
      s1_has_q  <= s_axis_tuser[0];
      s1_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= aip_pkg::clear_state(aip_pkg::RST_BASE);
      seen_q <= '0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        st_q   <= aip_pkg::clear_state(base_q);
        seen_q <= '0;
      end else begin
        st_q   <= unit_st;
        seen_q <= take ? seen_q + aip_pkg::SEEN_W'(1) : seen_q;
      end
    end else if (cfg_wr && (cfg_idx == aip_pkg::CFG_BASE) && (seen_q == '0) &&
                 (st_q.phase == aip_pkg::PH_WS)) begin
      st_q.base <= pwdata[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (fin_free) begin
      fin_valid_q <= s1_adv && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_free && s1_adv && s1_last_q) begin
      fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fin_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_adv) begin
      out_value_q  <= res.value;
      out_status_q <= res.status;
      out_count_q  <= res.count;
    end
  end

  a_err_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tuser == aip_pkg::ST_FORMAT) ||
                      (m_axis_tuser == aip_pkg::ST_ARG))
    |-> (m_axis_tdata[70:0] == '0))
    else $error("error result carries a value or count");

  a_last_snap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> fin_valid_q)
    else $error("end of string lost before the snapshot stage");

  a_snap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid_q && !out_free |=> fin_valid_q && $stable(fin_q))
    else $error("snapshot dropped while the result register is blocked");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> (st_q.phase == aip_pkg::PH_WS) && (st_q.cnt == '0) &&
                            (seen_q == '0))
    else $error("parse state not cleared after end of string");

endmodule
